>>> hdl/smm_pkg.sv
// Shared types and constants for the square matrix multiplier.
// No dependencies; imported by smm_ctrl, smm_datapath, square_matrix_multiply and tb_top.
package smm_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int SIZE_W  = 5;
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = 36;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(MAX_DIM);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_A = 2'd0,
        FUNC_WRITE_B = 2'd1,
        FUNC_ROW     = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd;
        logic             first;
        logic             last_k;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] col;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_active;
    } dp_status_t;

endpackage

>>> hdl/smm_ctrl.sv
// Controller for the square matrix multiplier: size register, handshake and
// the row/column/term sequencer. Depends on smm_pkg.
module smm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [smm_pkg::FUNC_W-1:0]    func,
    input  logic [smm_pkg::IDX_W-1:0]     row_index,
    input  logic [smm_pkg::IDX_W-1:0]     col_index,
    input  logic                          cfg_valid,
    input  logic [smm_pkg::SIZE_W-1:0]    cfg_size,
    input  smm_pkg::dp_status_t           status,
    output logic                          busy,
    output logic                          cfg_ready,
    output smm_pkg::ctrl_cmd_t            cmd
);
    import smm_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    c_reg, c_next;
    logic [SIZE_W-1:0]   eff_size;
    logic                accept;
    logic                row_ok;
    logic                col_ok;
    logic                last_k;
    logic                last_col;

    assign eff_size = (size_reg > SIZE_LIMIT) ? SIZE_LIMIT : size_reg;
    assign accept   = start && !busy;
    assign row_ok   = {1'b0, row_index} < eff_size;
    assign col_ok   = {1'b0, col_index} < eff_size;
    assign last_k   = {1'b0, k_reg} == (eff_size - SIZE_W'(1));
    assign last_col = {1'b0, c_reg} == (eff_size - SIZE_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_RESET;
            row_reg   <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_size;
            end
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func_t'(func) == FUNC_ROW && row_ok)
                begin
                    state_next = ST_RUN;
                    row_next   = row_index;
                    k_next     = '0;
                    c_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    k_next = '0;
                    if (last_col)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_active)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy         = 1'b0;
        cfg_ready    = 1'b0;
        cmd          = '0;
        cmd.row      = row_reg;
        cmd.k        = k_reg;
        cmd.col      = c_reg;
        cmd.first    = (k_reg == '0);
        cmd.last_k   = last_k;
        cmd.last_col = last_col;
        unique case (state_reg)
            ST_IDLE:
            begin
                // hold the size while a word is being taken
                cfg_ready = !start;
                if (accept && row_ok && col_ok)
                begin
                    unique case (func_t'(func))
                        FUNC_WRITE_A: cmd.wr_a = 1'b1;
                        FUNC_WRITE_B: cmd.wr_b = 1'b1;
                        default:      cmd.wr_a = 1'b0;
                    endcase
                end
            end
            ST_RUN:
            begin
                busy   = 1'b1;
                cmd.rd = 1'b1;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_read_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.rd)
        else $error("element read issued while not busy");

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ({1'b0, k_reg} < eff_size && {1'b0, c_reg} < eff_size))
        else $error("term or column counter beyond matrix size");

    a_row_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_k && last_col) |=> (state_reg == ST_DRAIN))
        else $error("final term of row did not enter drain");

    a_no_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(cmd.wr_a || cmd.wr_b))
        else $error("element write while busy");
`endif

endmodule

>>> hdl/smm_datapath.sv
// Datapath for the square matrix multiplier: element memories, multiplier,
// accumulator and result registers. Depends on smm_pkg.
module smm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smm_pkg::ctrl_cmd_t                cmd,
    input  logic [smm_pkg::IDX_W-1:0]         row_index,
    input  logic [smm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [smm_pkg::DATA_W-1:0] element_value,
    output smm_pkg::dp_status_t               status,
    output logic                              result_valid,
    output logic [smm_pkg::IDX_W-1:0]         out_col,
    output logic signed [smm_pkg::SUM_W-1:0]  product_sum,
    output logic                              last
);
    import smm_pkg::*;

    logic [DATA_W-1:0]        mem_a [DEPTH];
    logic [DATA_W-1:0]        mem_b [DEPTH];
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;

    logic signed [DATA_W-1:0] a_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_last_k_reg;
    logic                     s1_last_col_reg;
    logic [IDX_W-1:0]         s1_col_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_last_k_reg;
    logic                     s2_last_col_reg;
    logic [IDX_W-1:0]         s2_col_reg;

    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  acc_reg;

    logic                     result_valid_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [SUM_W-1:0]  product_sum_reg;
    logic                     last_reg;

    assign wr_addr   = {row_index, col_index};
    assign rd_addr_a = {cmd.row, cmd.k};
    assign rd_addr_b = {cmd.k, cmd.col};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
        begin
            mem_a[wr_addr] <= element_value;
        end
        if (cmd.rd)
        begin
            a_rd_reg <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
        begin
            mem_b[wr_addr] <= element_value;
        end
        if (cmd.rd)
        begin
            b_rd_reg <= mem_b[rd_addr_b];
        end
    end

    assign prod_next = a_rd_reg * b_rd_reg;
    assign prod_ext  = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next  = s2_first_reg ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= cmd.rd;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_last_k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg    <= cmd.first;
        s1_last_k_reg   <= cmd.last_k;
        s1_last_col_reg <= cmd.last_col;
        s1_col_reg      <= cmd.col;

        prod_reg        <= prod_next;
        s2_first_reg    <= s1_first_reg;
        s2_last_k_reg   <= s1_last_k_reg;
        s2_last_col_reg <= s1_last_col_reg;
        s2_col_reg      <= s1_col_reg;

        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_last_k_reg)
        begin
            product_sum_reg <= acc_next;
            out_col_reg     <= s2_col_reg;
            last_reg        <= s2_last_col_reg;
        end
    end

    assign status.pipe_active = s1_valid_reg || s2_valid_reg;
    assign result_valid       = result_valid_reg;
    assign out_col            = out_col_reg;
    assign product_sum        = product_sum_reg;
    assign last               = last_reg;

endmodule

>>> hdl/square_matrix_multiply.sv
// Top level of the square matrix multiplier: joins controller and datapath.
// Depends on smm_pkg, smm_ctrl and smm_datapath.
//
// Computes rows of C = A x B on signed Q1.15 elements with exact 36-bit Q6.30
// sums. A load (func 0 for A, 1 for B) is dropped if its row or column is not
// below the matrix size; func 3 does nothing. A row request keeps busy high
// until its last result is shown; one multiply-accumulate unit reads one A
// and one B element per cycle from the single-read-port element memories,
// and each column's result appears on result_valid in column order, with
// last on the final column. The receiver cannot stall: every result is shown
// for exactly one cycle. Reading an element that was never written gives an
// undefined result. matrix_size resets to 16, is capped at 16, and is taken
// only while busy and start are low.
module square_matrix_multiply (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [smm_pkg::FUNC_W-1:0]        func,
    input  logic [smm_pkg::IDX_W-1:0]         row_index,
    input  logic [smm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [smm_pkg::DATA_W-1:0] element_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]        matrix_size,
    output logic                              result_valid,
    output logic [smm_pkg::IDX_W-1:0]         out_col,
    output logic signed [smm_pkg::SUM_W-1:0]  product_sum,
    output logic                              last
);
    import smm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    smm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .row_index (row_index),
        .col_index (col_index),
        .cfg_valid (cfg_valid),
        .cfg_size  (matrix_size),
        .status    (status),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    smm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .status        (status),
        .result_valid  (result_valid),
        .out_col       (out_col),
        .product_sum   (product_sum),
        .last          (last)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for square_matrix_multiply: loads A and B, requests rows of C.
// Depends on smm_pkg and the square_matrix_multiply RTL; expected sums are computed here.
module tb_top;
    import smm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 8;

    typedef struct {
        logic [FUNC_W-1:0]        op;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        int unsigned              gap;
        bit                       drain;
    } smm_word_t;

    typedef struct {
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } c_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [FUNC_W-1:0] func = '0;
    logic [IDX_W-1:0] row_index = '0;
    logic [IDX_W-1:0] col_index = '0;
    logic signed [DATA_W-1:0] element_value = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SIZE_W-1:0] matrix_size = SIZE_RESET;
    logic result_valid;
    logic [IDX_W-1:0] out_col;
    logic signed [SUM_W-1:0] product_sum;
    logic last;

    smm_word_t pending_words[$];
    c_entry_t sums_due[$];
    smm_word_t word_now;

    logic signed [DATA_W-1:0] mat_a [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] mat_b [MAX_DIM][MAX_DIM];
    logic [SIZE_W-1:0] size_now = SIZE_RESET;

    bit a_written [MAX_DIM][MAX_DIM];
    bit b_written [MAX_DIM][MAX_DIM];
    int gen_n = 16;
    int burst_left = 0;

    int fail_count = 0;
    int idle_cycles = 0;
    int unsigned wait_cnt = 0;
    bit launch_next;

    square_matrix_multiply i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .matrix_size   (matrix_size),
        .result_valid  (result_valid),
        .out_col       (out_col),
        .product_sum   (product_sum),
        .last          (last)
    );

    always #2 clk = ~clk;

    function automatic int eff_dim(input logic [SIZE_W-1:0] s);
        return (s > SIZE_LIMIT) ? int'(SIZE_LIMIT) : int'(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic predict_word(input smm_word_t w);
        int n;
        longint acc;
        c_entry_t e;
        n = eff_dim(size_now);
        case (w.op)
            FUNC_WRITE_A:
                if (w.row < n && w.col < n)
                    mat_a[w.row][w.col] = w.value;
            FUNC_WRITE_B:
                if (w.row < n && w.col < n)
                    mat_b[w.row][w.col] = w.value;
            FUNC_ROW:
                if (w.row < n)
                begin
                    for (int c = 0; c < n; c++)
                    begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(mat_a[w.row][k]) * longint'(mat_b[k][c]);
                        e.col = IDX_W'(c);
                        e.sum = SUM_W'(acc);
                        e.last = (c == n - 1);
                        sums_due.push_back(e);
                    end
                end
            default: ;
        endcase
    endtask

    // driver: hold each word until taken, then draw the next after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            wait_cnt = 0;
        end
        else
        begin
            launch_next = start;
            if (start && !busy)
            begin
                predict_word(word_now);
                launch_next = 1'b0;
            end
            if (!launch_next && pending_words.size() > 0)
            begin
                if (wait_cnt < pending_words[0].gap)
                    wait_cnt++;
                else if (!pending_words[0].drain || sums_due.size() == 0)
                begin
                    word_now = pending_words.pop_front();
                    wait_cnt = 0;
                    launch_next = 1'b1;
                    func <= word_now.op;
                    row_index <= word_now.row;
                    col_index <= word_now.col;
                    element_value <= word_now.value;
                end
            end
            start <= launch_next;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (sums_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: col %0d sum %0d last %0b",
                             out_col, product_sum, last);
            end
            else
            begin
                c_entry_t e;
                e = sums_due.pop_front();
                if (out_col !== e.col || product_sum !== e.sum || last !== e.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("mismatch: expected col %0d sum %0d last %0b, ",
                               e.col, e.sum, e.last);
                        $display("got col %0d sum %0d last %0b",
                                 out_col, product_sum, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("square_matrix_multiply test failed");
                $finish;
            end
        end
    end

    task automatic gen_word(input logic [FUNC_W-1:0] op, input int r, input int c,
                            input logic signed [DATA_W-1:0] v);
        smm_word_t w;
        w.op = op;
        w.row = IDX_W'(r);
        w.col = IDX_W'(c);
        w.value = v;
        if (burst_left > 0)
        begin
            w.gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            burst_left = $urandom_range(8, 16);
            w.gap = 0;
        end
        else
            w.gap = $urandom_range(0, 17);
        w.drain = ($urandom_range(0, 24) == 0);
        if (r < gen_n && c < gen_n)
        begin
            if (op == FUNC_WRITE_A)
                a_written[r][c] = 1'b1;
            if (op == FUNC_WRITE_B)
                b_written[r][c] = 1'b1;
        end
        pending_words.push_back(w);
    endtask

    // fill every element the row will read before requesting it
    task automatic request_row(input int r);
        if (r < gen_n)
        begin
            for (int k = 0; k < gen_n; k++)
                if (!a_written[r][k])
                    gen_word(FUNC_WRITE_A, r, k, rand_element());
            for (int k = 0; k < gen_n; k++)
                for (int c = 0; c < gen_n; c++)
                    if (!b_written[k][c])
                        gen_word(FUNC_WRITE_B, k, c, rand_element());
        end
        gen_word(FUNC_ROW, r, $urandom_range(0, 15), rand_element());
    endtask

    task automatic random_word();
        int sel;
        int r;
        int c;
        sel = $urandom_range(0, 19);
        if (gen_n > 0 && $urandom_range(0, 6) != 0)
        begin
            r = $urandom_range(0, gen_n - 1);
            c = $urandom_range(0, gen_n - 1);
        end
        else
        begin
            r = $urandom_range(0, 15);
            c = $urandom_range(0, 15);
        end
        if (sel < 9)
            gen_word(FUNC_WRITE_A, r, c, rand_element());
        else if (sel < 15)
            gen_word(FUNC_WRITE_B, r, c, rand_element());
        else if (sel < 19)
            request_row(r);
        else
            gen_word(FUNC_NONE, r, c, rand_element());
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        matrix_size <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_now = v;
        gen_n = eff_dim(v);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || start || sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    logic [SIZE_W-1:0] phase_sizes [PHASES] = '{5'd1, 5'd3, 5'd0, 5'd16, 5'd5, 5'd31, 5'd8, 5'd4};
    int phase_items [PHASES] = '{30, 35, 8, 20, 35, 12, 35, 35};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_size(5'd2);
        gen_word(FUNC_WRITE_A, 0, 0, -16'sd32768);
        gen_word(FUNC_WRITE_A, 0, 1, -16'sd32768);
        gen_word(FUNC_WRITE_A, 1, 0, 16'sd32767);
        gen_word(FUNC_WRITE_A, 1, 1, -16'sd1);
        gen_word(FUNC_WRITE_B, 0, 0, -16'sd32768);
        gen_word(FUNC_WRITE_B, 0, 1, 16'sd32767);
        gen_word(FUNC_WRITE_B, 1, 0, -16'sd32768);
        gen_word(FUNC_WRITE_B, 1, 1, 16'sd32767);
        gen_word(FUNC_WRITE_A, 2, 0, 16'sh5555);
        gen_word(FUNC_WRITE_B, 0, 15, -16'sh5556);
        gen_word(FUNC_WRITE_A, 15, 15, -16'sd1);
        gen_word(FUNC_NONE, 15, 15, -16'sd1);
        request_row(0);
        request_row(1);
        request_row(2);
        request_row(15);
        gen_word(FUNC_WRITE_A, 0, 0, '0);
        request_row(0);
        pending_words[pending_words.size() - 1].drain = 1'b1;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_size(phase_sizes[p]);
            if (gen_n == MAX_DIM && phase_sizes[p] == SIZE_LIMIT)
            begin
                for (int k = 0; k < MAX_DIM; k++)
                    gen_word(FUNC_WRITE_A, 0, k, -16'sd32768);
                for (int k = 0; k < MAX_DIM; k++)
                    for (int c = 0; c < MAX_DIM; c++)
                        gen_word(FUNC_WRITE_B, k, c, -16'sd32768);
                request_row(0);
                for (int k = 0; k < MAX_DIM; k++)
                    gen_word(FUNC_WRITE_A, 15, k, 16'sd32767);
                request_row(15);
            end
            for (int i = 0; i < phase_items[p]; i++)
                random_word();
            wait_idle();
        end

        if (fail_count == 0 && sums_due.size() == 0)
            $display("square_matrix_multiply test passed");
        else
            $display("square_matrix_multiply test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/smm_pkg.sv
hdl/smm_ctrl.sv
hdl/smm_datapath.sv
hdl/square_matrix_multiply.sv
test/tb_top.sv
